// ===== src/npce_pkg.sv =====
// Shared types, constants and the non-printing interval table for the
// caret-notation escaper. No dependencies.
`timescale 1ns / 1ps

package npce_pkg;

  localparam int CP_W            = 21;
  localparam int TDATA_W         = 24;
  localparam int NUM_SPANS       = 20;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CP_W-1:0] CARET     = 21'h00005E;
  localparam logic [CP_W-1:0] QUESTION  = 21'h00003F;
  localparam logic [CP_W-1:0] CTRL_FLIP = 21'h000040;
  localparam logic [CP_W-1:0] ASCII_US  = 21'h00001F;
  localparam logic [CP_W-1:0] ASCII_DEL = 21'h00007F;

  // Cc and Cf intervals, inclusive bounds
  localparam logic [CP_W-1:0] SPAN_LO [NUM_SPANS] = '{
    21'h00000, 21'h0007F, 21'h000AD, 21'h00600, 21'h0061C,
    21'h006DD, 21'h0070F, 21'h008E2, 21'h0180E, 21'h0200B,
    21'h0202A, 21'h02060, 21'h02066, 21'h0FEFF, 21'h0FFF9,
    21'h110BD, 21'h1BCA0, 21'h1D173, 21'hE0001, 21'hE0020
  };
  localparam logic [CP_W-1:0] SPAN_HI [NUM_SPANS] = '{
    21'h0001F, 21'h0009F, 21'h000AD, 21'h00605, 21'h0061C,
    21'h006DD, 21'h0070F, 21'h008E2, 21'h0180E, 21'h0200F,
    21'h0202E, 21'h02064, 21'h0206F, 21'h0FEFF, 21'h0FFFB,
    21'h110BD, 21'h1BCA3, 21'h1D17A, 21'hE0001, 21'hE007F
  };

  // Classified item handed from front to back
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            hidden;
    logic            ctrl;
  } npce_item_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic pending;
    logic pop;
  } npce_emit_stat_t;

  // Parallel interval compare over the whole table
  function automatic logic span_hit(logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_SPANS; i++) begin
      if (cp >= SPAN_LO[i] && cp <= SPAN_HI[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_ctrl(logic [CP_W-1:0] cp);
    return (cp <= ASCII_US) || (cp == ASCII_DEL);
  endfunction

endpackage

// ===== src/npce_classify.sv =====
// Front end: accepts code points, classifies them and holds them in one
// pipeline register. Depends on npce_pkg.
`timescale 1ns / 1ps

module npce_classify import npce_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [CP_W-1:0] in_cp,
  output logic            item_valid,
  input  logic            item_ready,
  output npce_item_t      item
);

  logic       valid;
  npce_item_t held;

  assign in_ready   = !valid || item_ready;
  assign item_valid = valid;
  assign item       = held;

  // Advance when the queue takes the held request or the stage is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Classify on the way in
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held.code_point <= in_cp;
      held.hidden     <= span_hit(in_cp);
      held.ctrl       <= is_ctrl(in_cp);
    end
  end

endmodule

// ===== src/npce_queue.sv =====
// Short FIFO between the classifier and the emitter.
// Depends on npce_pkg for the item type.
`timescale 1ns / 1ps

module npce_queue import npce_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  npce_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output npce_item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  npce_item_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming request
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== src/npce_emit.sv =====
// Back end: expands each classified item into one or two output beats
// held in an output register. Depends on npce_pkg.
`timescale 1ns / 1ps

module npce_emit import npce_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  npce_item_t      item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_char,
  output logic            out_last,
  output npce_emit_stat_t stat
);

  logic            valid;
  logic            pending;
  logic [CP_W-1:0] second;
  logic            load;

  assign load       = !valid || out_ready;
  assign item_ready = load && !pending;
  assign out_valid  = valid;
  assign stat.pending = pending;
  assign stat.pop     = item_valid && item_ready;

  // Control: output valid and second-beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      pending <= 1'b0;
    end else if (load) begin
      if (pending) begin
        valid   <= 1'b1;
        pending <= 1'b0;
      end else begin
        valid   <= item_valid;
        pending <= item_valid && item.hidden;
      end
    end
  end

  // Payload: caret first for hidden characters, then the escape letter
  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        out_char <= second;
        out_last <= 1'b1;
      end else if (item_valid) begin
        if (item.hidden) begin
          out_char <= CARET;
          out_last <= 1'b0;
          second   <= item.ctrl ? (item.code_point ^ CTRL_FLIP) : QUESTION;
        end else begin
          out_char <= item.code_point;
          out_last <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/nonprintable_char_escaper.sv =====
// Caret-notation escaper: one code point per request in, one or two
// characters out, through the classifier register, queue and output register.
// Throughput: one request per cycle for printable characters while the output
// is not stalled; an escaped character takes two output beats, caret then letter, since there is a single output port.
// A 2-entry queue decouples the classifier from the emitter.
// Reset (rst, synchronous) empties all stages; no other state is kept.
`timescale 1ns / 1ps

module nonprintable_char_escaper import npce_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // [20:0] code_point, [23:21] zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // [20:0] out_char, [23:21] zero
  output logic               m_axis_tlast
);

  logic            front_valid;
  logic            front_ready;
  npce_item_t      front_item;
  logic            q_valid;
  logic            q_ready;
  npce_item_t      q_item;
  logic [CP_W-1:0] out_char;
  npce_emit_stat_t emit_stat;

  npce_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cp      (s_axis_tdata[CP_W-1:0]),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  npce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  npce_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (out_char),
    .out_last   (m_axis_tlast),
    .stat       (emit_stat)
  );

  assign m_axis_tdata = {{(TDATA_W - CP_W){1'b0}}, out_char};

  // A beat that is not the last is always the caret
  a_caret_first: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[CP_W-1:0] == CARET)
    else $error("non-final beat is not a caret");

  // Once the caret is taken, the escape letter follows in the next cycle
  a_second_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("escape letter did not follow caret");

  // No request leaves the queue while a second beat is owed
  a_no_pop_pending: assert property (@(posedge clk) disable iff (rst)
    emit_stat.pending |-> !emit_stat.pop)
    else $error("queue popped while second beat pending");

  // A pending second beat means the caret is in the output register
  a_pending_caret: assert property (@(posedge clk) disable iff (rst)
    emit_stat.pending |-> m_axis_tvalid && !m_axis_tlast)
    else $error("pending flag without caret in output register");

endmodule

// ===== tb/escape_checker.sv =====
// Scoreboard for the caret-notation escaper: watches both stream channels,
// predicts the escaped characters of every accepted request and compares.
// Depends on npce_pkg for widths and character constants.
`timescale 1ns / 1ps

module escape_checker import npce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [TDATA_W-1:0] m_axis_tdata,   // [20:0] out_char, [23:21] zero
  input  logic               m_axis_tlast,
  output int                 chars_due,
  output int                 fail_count
);

  typedef struct packed {
    logic [CP_W-1:0] ch;
    logic            last;
  } out_char_t;

  localparam int N_HIDDEN = 20;

  // Cc and Cf code point ranges, inclusive
  localparam logic [CP_W-1:0] HIDDEN_LO [N_HIDDEN] = '{
    21'h00000, 21'h0007F, 21'h000AD, 21'h00600, 21'h0061C,
    21'h006DD, 21'h0070F, 21'h008E2, 21'h0180E, 21'h0200B,
    21'h0202A, 21'h02060, 21'h02066, 21'h0FEFF, 21'h0FFF9,
    21'h110BD, 21'h1BCA0, 21'h1D173, 21'hE0001, 21'hE0020
  };
  localparam logic [CP_W-1:0] HIDDEN_HI [N_HIDDEN] = '{
    21'h0001F, 21'h0009F, 21'h000AD, 21'h00605, 21'h0061C,
    21'h006DD, 21'h0070F, 21'h008E2, 21'h0180E, 21'h0200F,
    21'h0202E, 21'h02064, 21'h0206F, 21'h0FEFF, 21'h0FFFB,
    21'h110BD, 21'h1BCA3, 21'h1D17A, 21'hE0001, 21'hE007F
  };

  out_char_t escaped_q[$];
  int        errors = 0;

  function automatic logic is_hidden_cp(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_HIDDEN; i++) begin
      if (cp >= HIDDEN_LO[i] && cp <= HIDDEN_HI[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Queue the characters one code point turns into
  task automatic escape_char(input logic [CP_W-1:0] cp);
    out_char_t c;
    if (!is_hidden_cp(cp)) begin
      c.ch   = cp;
      c.last = 1'b1;
      escaped_q.push_back(c);
    end else begin
      c.ch   = CARET;
      c.last = 1'b0;
      escaped_q.push_back(c);
      if (cp <= ASCII_US || cp == ASCII_DEL) c.ch = cp ^ CTRL_FLIP;
      else c.ch = QUESTION;
      c.last = 1'b1;
      escaped_q.push_back(c);
    end
  endtask

  // Compare each output beat with the oldest prediction, then take new requests
  always @(posedge clk) begin
    out_char_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (escaped_q.size() == 0) begin
          $display("%0t: unexpected output: expected none, actual tdata=%h tlast=%b",
                   $time, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = escaped_q.pop_front();
          if (m_axis_tdata !== {{(TDATA_W-CP_W){1'b0}}, want.ch}) begin
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.ch, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: tlast mismatch: expected %b, actual %b",
                     $time, want.last, m_axis_tlast);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) escape_char(s_axis_tdata[CP_W-1:0]);
    end
    chars_due  <= escaped_q.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/tb.sv =====
// Top of the escaper testbench: clock, reset, request stimulus and output
// back-pressure. Depends on npce_pkg, nonprintable_char_escaper, escape_checker.
`timescale 1ns / 1ps

module tb;
  import npce_pkg::*;

  localparam int N_RANDOM    = 1000;
  localparam int CYCLE_LIMIT = 1000000;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  int                 chars_due;
  int                 fail_count;
  int                 cycles = 0;
  bit                 calm = 1'b0;

  nonprintable_char_escaper i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  escape_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .chars_due     (chars_due),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random code point, weighted toward range edges and the ASCII/Latin-1 area
  function automatic logic [CP_W-1:0] pick_code_point();
    int              r;
    int              k;
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    r  = $urandom_range(0, 99);
    k  = $urandom_range(0, NUM_SPANS - 1);
    lo = SPAN_LO[k];
    hi = SPAN_HI[k];
    if (r < 25) return lo + CP_W'($urandom_range(0, hi - lo));
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return lo - 1'b1;
        1:       return lo;
        2:       return hi;
        default: return hi + 1'b1;
      endcase
    end
    if (r < 62) return CP_W'($urandom_range(0, 'h7F));
    if (r < 70) return CP_W'($urandom_range('h80, 'hFF));
    if (r < 76) return CP_W'($urandom_range('hD800, 'hDFFF));
    if (r < 80) return {5'($urandom_range(0, 'h1F)), 16'hFFFE | 16'($urandom_range(0, 1))};
    return CP_W'($urandom_range(0, 'h1FFFFF));
  endfunction

  // Present one request and hold it until accepted
  task automatic send_char(input logic [CP_W-1:0] cp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W-CP_W){1'b0}}, cp};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Stop sending until every predicted character has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (chars_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Output back-pressure
  initial begin
    int busy;
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      busy = calm ? 50 : $urandom_range(1, 6);
      repeat (busy) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    logic [CP_W-1:0] directed [24];
    directed = '{
      21'h000000, 21'h00001F, 21'h000020, 21'h000041, 21'h00005E,
      21'h00007E, 21'h00007F, 21'h000080, 21'h00009F, 21'h0000A0,
      21'h0000AD, 21'h0000FF, 21'h000600, 21'h00200B, 21'h00D800,
      21'h00FEFF, 21'h00FFFE, 21'h0110BD, 21'h0E0001, 21'h0E007F,
      21'h0E0080, 21'h10FFFF, 21'h110000, 21'h1FFFFF
    };
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: field extremes, both escape forms, out-of-range values
    foreach (directed[i]) send_char(directed[i]);
    drain();

    // Random traffic in phases, some without any idling
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 199) == 0) drain();
      send_char(pick_code_point());
    end

    // Wait out the tail, then wait on for stray beats
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
